// ===== design/dorm_pkg.sv =====
package dorm_pkg;

    localparam int RULES_DEFAULT = 16;
    localparam int CODE_W        = 4;
    localparam int CODE_NIBBLES  = 9;
    localparam int CODES_W       = CODE_W * CODE_NIBBLES;
    localparam int MINUTE_W      = 11;
    localparam int CFG_W         = 5;
    localparam int NIB_CLEARANCE = 1;
    localparam int NIB_CLASS     = 4;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        CAUSE_CLEARANCE = 2'd0,
        CAUSE_DENY      = 2'd1,
        CAUSE_ALLOW     = 2'd2,
        CAUSE_DEFAULT   = 2'd3
    } cause_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_HOLD
    } state_t;

    typedef struct packed
    {
        logic [MINUTE_W-1:0] win_end;
        logic [MINUTE_W-1:0] win_start;
        logic                win_used;
        logic                denies;
        logic [CODES_W-1:0]  codes;
    } rule_t;

    // codes 1..4 rank upwards, any other code ranks below them all
    function automatic logic [2:0] rank_of(input logic [CODE_W-1:0] code);
        logic [2:0] r;
        begin
            r = 3'd0;
            if (code >= 4'd1 && code <= 4'd4)
            begin
                r = code[2:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== design/deny_overrides_rule_match_top.sv =====
// load item: accepted and written to the table together, the next beat can follow straight after
// evaluate item: clearance check, then a scan of up to n = min(rules_in_use, RULES) rules in order
// through the single rule compare unit and table read port (n = 0 on a clearance deny), ending
// early on a matching deny; no new item is taken until the result is in the output register;
// a result that meets a stalled output register is parked and the input stalls until it drains
// reset clears the sequencer, the output valid and rules_in_use; the rule table is not cleared
module deny_overrides_rule_match_top #(
    parameter int RULES = dorm_pkg::RULES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [3:0]                           rule_slot,
    input  logic [dorm_pkg::CODES_W-1:0]         attr_codes,
    input  logic                                 rule_denies,
    input  logic                                 window_used,
    input  logic [dorm_pkg::MINUTE_W-1:0]        window_start,
    input  logic [dorm_pkg::MINUTE_W-1:0]        window_end,
    input  logic [dorm_pkg::MINUTE_W-1:0]        request_minute,
    input  logic                                 minute_valid,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 allowed,
    output logic [1:0]                           cause,
    output logic [3:0]                           deciding_rule,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dorm_pkg::CFG_W-1:0]           cfg_data
);

    localparam int IDX_W  = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W  = $clog2(RULES + 1);
    localparam int SLOT_W = (IDX_W > 4) ? IDX_W : 4;

    dorm_pkg::rule_t mem [RULES];
    dorm_pkg::rule_t rd_data_reg;
    dorm_pkg::rule_t wr_entry;
    logic            wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [SLOT_W-1:0] slot_w;

    dorm_pkg::state_t state_reg, state_next;
    logic [dorm_pkg::CODES_W-1:0]  codes_reg, codes_next;
    logic [dorm_pkg::MINUTE_W-1:0] minute_reg, minute_next;
    logic                          mvalid_reg, mvalid_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              limit_reg, limit_next;
    logic                          have_allow_reg, have_allow_next;
    logic [CNT_W-1:0]              allow_idx_reg, allow_idx_next;
    logic                          res_allowed_reg, res_allowed_next;
    logic [1:0]                    res_cause_reg, res_cause_next;
    logic [CNT_W-1:0]              res_rule_reg, res_rule_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          allowed_reg, allowed_next;
    logic [1:0]                    cause_reg, cause_next;
    logic [3:0]                    rule_out_reg, rule_out_next;
    logic [dorm_pkg::CFG_W-1:0]    rules_in_use_reg, rules_in_use_next;

    logic                 accept;
    logic                 out_free;
    logic                 fin;
    logic                 fin_allowed;
    logic [1:0]           fin_cause;
    logic [CNT_W-1:0]     fin_rule;
    logic [CNT_W-1:0]     idx_plus;
    logic                 codes_ok;
    logic                 window_ok;
    logic                 match;
    logic [dorm_pkg::CODE_W-1:0] rc;
    logic [dorm_pkg::CODE_W-1:0] qc;
    logic [dorm_pkg::CODE_W-1:0] clr;
    logic [dorm_pkg::CODE_W-1:0] cls;
    logic [31:0]          rules_wide;
    logic [CNT_W+3:0]     rule_wide;

    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != dorm_pkg::ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign allowed       = allowed_reg;
    assign cause         = cause_reg;
    assign deciding_rule = rule_out_reg;

    assign slot_w   = SLOT_W'(rule_slot);
    assign wr_addr  = slot_w[IDX_W-1:0];
    assign wr_en    = accept && (opcode == dorm_pkg::OP_LOAD) && (32'(rule_slot) < RULES);
    assign wr_entry = '{win_end: window_end, win_start: window_start, win_used: window_used,
                        denies: rule_denies, codes: attr_codes};
    assign idx_plus = CNT_W'(idx_reg + CNT_W'(1));
    assign rd_addr  = (state_reg == dorm_pkg::ST_SCAN) ? idx_plus[IDX_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // shared compare unit: one rule against the held request
    always_comb
    begin
        codes_ok = 1'b1;
        for (int k = 0; k < dorm_pkg::CODE_NIBBLES; k++)
        begin
            rc = rd_data_reg.codes[k*dorm_pkg::CODE_W +: dorm_pkg::CODE_W];
            qc = codes_reg[k*dorm_pkg::CODE_W +: dorm_pkg::CODE_W];
            if (rc != '0 && rc != qc)
            begin
                codes_ok = 1'b0;
            end
        end
        window_ok = !rd_data_reg.win_used
                    || (mvalid_reg && minute_reg >= rd_data_reg.win_start
                        && minute_reg <= rd_data_reg.win_end);
        match = codes_ok && window_ok;
    end

    always_comb
    begin
        state_next        = state_reg;
        codes_next        = codes_reg;
        minute_next       = minute_reg;
        mvalid_next       = mvalid_reg;
        idx_next          = idx_reg;
        limit_next        = limit_reg;
        have_allow_next   = have_allow_reg;
        allow_idx_next    = allow_idx_reg;
        res_allowed_next  = res_allowed_reg;
        res_cause_next    = res_cause_reg;
        res_rule_next     = res_rule_reg;
        out_valid_next    = out_valid_reg && out_stall;
        allowed_next      = allowed_reg;
        cause_next        = cause_reg;
        rule_out_next     = rule_out_reg;
        rules_in_use_next = rules_in_use_reg;
        fin               = 1'b0;
        fin_allowed       = 1'b0;
        fin_cause         = dorm_pkg::CAUSE_DEFAULT;
        fin_rule          = '0;
        clr = codes_reg[dorm_pkg::NIB_CLEARANCE*dorm_pkg::CODE_W +: dorm_pkg::CODE_W];
        cls = codes_reg[dorm_pkg::NIB_CLASS*dorm_pkg::CODE_W +: dorm_pkg::CODE_W];
        rules_wide = 32'(rules_in_use_reg);
        rule_wide  = '0;

        if (cfg_valid && cfg_ready)
        begin
            rules_in_use_next = cfg_data;
        end

        case (state_reg)
            dorm_pkg::ST_IDLE:
            begin
                if (accept && opcode == dorm_pkg::OP_EVAL)
                begin
                    codes_next      = attr_codes;
                    minute_next     = request_minute;
                    mvalid_next     = minute_valid;
                    have_allow_next = 1'b0;
                    idx_next        = '0;
                    state_next      = dorm_pkg::ST_CHECK;
                end
            end
            dorm_pkg::ST_CHECK:
            begin
                if (rules_wide > RULES)
                begin
                    limit_next = CNT_W'(RULES);
                end
                else
                begin
                    limit_next = rules_wide[CNT_W-1:0];
                end
                if (clr != '0 && cls != '0
                    && dorm_pkg::rank_of(clr) < dorm_pkg::rank_of(cls))
                begin
                    fin       = 1'b1;
                    fin_cause = dorm_pkg::CAUSE_CLEARANCE;
                end
                else if (limit_next == '0)
                begin
                    fin       = 1'b1;
                    fin_cause = dorm_pkg::CAUSE_DEFAULT;
                end
                else
                begin
                    state_next = dorm_pkg::ST_SCAN;
                end
            end
            dorm_pkg::ST_SCAN:
            begin
                idx_next = idx_plus;
                if (match && rd_data_reg.denies)
                begin
                    fin       = 1'b1;
                    fin_cause = dorm_pkg::CAUSE_DENY;
                    fin_rule  = idx_reg;
                end
                else
                begin
                    if (match)
                    begin
                        have_allow_next = 1'b1;
                        allow_idx_next  = idx_reg;
                    end
                    // last rule of the scan
                    if (idx_plus == limit_reg)
                    begin
                        fin = 1'b1;
                        if (have_allow_next)
                        begin
                            fin_allowed = 1'b1;
                            fin_cause   = dorm_pkg::CAUSE_ALLOW;
                            fin_rule    = allow_idx_next;
                        end
                    end
                end
            end
            dorm_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    rule_wide      = {4'b0, res_rule_reg};
                    out_valid_next = 1'b1;
                    allowed_next   = res_allowed_reg;
                    cause_next     = res_cause_reg;
                    rule_out_next  = rule_wide[3:0];
                    state_next     = dorm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dorm_pkg::ST_IDLE;
            end
        endcase

        if (fin)
        begin
            res_allowed_next = fin_allowed;
            res_cause_next   = fin_cause;
            res_rule_next    = fin_rule;
            if (out_free)
            begin
                rule_wide      = {4'b0, fin_rule};
                out_valid_next = 1'b1;
                allowed_next   = fin_allowed;
                cause_next     = fin_cause;
                rule_out_next  = rule_wide[3:0];
                state_next     = dorm_pkg::ST_IDLE;
            end
            else
            begin
                state_next = dorm_pkg::ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dorm_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
            rules_in_use_reg <= '0;
            have_allow_reg   <= 1'b0;
            idx_reg          <= '0;
            limit_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            rules_in_use_reg <= rules_in_use_next;
            have_allow_reg   <= have_allow_next;
            idx_reg          <= idx_next;
            limit_reg        <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        codes_reg       <= codes_next;
        minute_reg      <= minute_next;
        mvalid_reg      <= mvalid_next;
        allow_idx_reg   <= allow_idx_next;
        res_allowed_reg <= res_allowed_next;
        res_cause_reg   <= res_cause_next;
        res_rule_reg    <= res_rule_next;
        allowed_reg     <= allowed_next;
        cause_reg       <= cause_next;
        rule_out_reg    <= rule_out_next;
    end

endmodule
